[rtl/core/drrip_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// DRRIP shared package
// Field widths, codes, fixed constants and structs used by the DRRIP
// replacement policy modules.
// ----------------------------------------------------------------------------
package drrip_pkg;

    localparam int CMD_W     = 1;
    localparam int CPU_ID_W  = 2;
    localparam int SET_IDX_W = 10;
    localparam int WAY_IDX_W = 3;
    localparam int VALID_W   = 8;

    localparam logic CMD_VICTIM = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic [1:0] RRPV_MAX  = 2'd3;
    localparam logic [1:0] RRPV_LONG = 2'd2;
    localparam logic [1:0] RRPV_NEAR = 2'd0;

    localparam int          SEED_W   = 36;
    localparam int          HALF_W   = 18;
    localparam int          CAND_LSB = 16;
    localparam int          CAND_W   = 20;
    localparam logic [30:0] LCG_MUL  = 31'd1103515245;
    localparam logic [13:0] LCG_ADD  = 14'd12345;

    typedef struct packed {
        logic done;
        logic row_we;
        logic tag_we;
    } t_init_ctl;

    typedef struct packed {
        logic       from_invalid;
        logic [2:0] way;
    } t_pick;

endpackage
`default_nettype wire

[rtl/core/drrip_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// DRRIP synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module drrip_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/core/drrip_init.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// DRRIP reset sequencer
// Clears both memories one row per cycle, then picks the leader sets with a
// 36-bit LCG, skipping sets that are already taken.
// ----------------------------------------------------------------------------
module drrip_init #(
    parameter int NUM_SETS             = 1024,
    parameter int NUM_CORES            = 4,
    parameter int DUEL_SETS_PER_POLICY = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [$clog2(2*NUM_CORES+1)-1:0] i_tag_rdata,
    output drrip_pkg::t_init_ctl                o_ctl,
    output logic [$clog2(NUM_SETS)-1:0]         o_addr,
    output logic [$clog2(2*NUM_CORES+1)-1:0]    o_tag
);

    localparam int SET_W   = $clog2(NUM_SETS);
    localparam int TAG_W   = $clog2(2*NUM_CORES+1);
    localparam int WANT    = (NUM_CORES*2*DUEL_SETS_PER_POLICY > NUM_SETS) ?
                             NUM_SETS : NUM_CORES*2*DUEL_SETS_PER_POLICY;
    localparam int GOT_W   = $clog2(WANT+1);
    localparam int PC_W    = (DUEL_SETS_PER_POLICY > 1) ? $clog2(DUEL_SETS_PER_POLICY) : 1;
    localparam int CORE_W  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int SEED_W  = drrip_pkg::SEED_W;
    localparam int HALF_W  = drrip_pkg::HALF_W;
    localparam int CAND_W  = drrip_pkg::CAND_W;
    localparam int RECIP_W = CAND_W + 1;
    localparam int QSH     = CAND_W + SET_W;

    // The quotient of a candidate by NUM_SETS is its product with this
    // reciprocal, shifted right by QSH; it is exact for every candidate value.
    localparam longint unsigned RECIP_L = ((64'd1 << QSH) / NUM_SETS) + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b0_0000_0001,
        S_MUL_LO = 9'b0_0000_0010,
        S_MUL_HI = 9'b0_0000_0100,
        S_ADD    = 9'b0_0000_1000,
        S_QUO    = 9'b0_0001_0000,
        S_REM    = 9'b0_0010_0000,
        S_READ   = 9'b0_0100_0000,
        S_CHECK  = 9'b0_1000_0000,
        S_DONE   = 9'b1_0000_0000
    } t_init_state;

    t_init_state         r_state, n_state;
    logic [SET_W-1:0]    r_cnt, n_cnt;
    logic [SEED_W-1:0]   r_seed, n_seed;
    logic [SEED_W-1:0]   r_prod_lo, n_prod_lo;
    logic [HALF_W-1:0]   r_prod_hi, n_prod_hi;
    logic [CAND_W-1:0]   r_div, n_div;
    logic [CAND_W-1:0]   r_quo, n_quo;
    logic [SET_W-1:0]    r_rem, n_rem;
    logic [GOT_W-1:0]    r_got, n_got;
    logic [PC_W-1:0]     r_pcnt, n_pcnt;
    logic                r_pol, n_pol;
    logic [CORE_W-1:0]   r_core, n_core;

    logic [48:0]               w_plo;
    logic [35:0]               w_phi;
    logic [SEED_W-1:0]         w_seed_new;
    logic [CAND_W+RECIP_W-1:0] w_qprod;
    logic [CAND_W-1:0]         w_qd;
    logic [CAND_W-1:0]         w_rem_full;
    logic                      w_free;

    assign w_plo      = r_seed[HALF_W-1:0] * drrip_pkg::LCG_MUL;
    assign w_phi      = r_seed[SEED_W-1:HALF_W] * drrip_pkg::LCG_MUL[HALF_W-1:0];
    assign w_seed_new = r_prod_lo + {r_prod_hi, {HALF_W{1'b0}}}
                        + SEED_W'(drrip_pkg::LCG_ADD);
    assign w_qprod    = r_div * RECIP;
    assign w_qd       = CAND_W'(r_quo * CAND_W'(NUM_SETS));
    assign w_rem_full = r_div - w_qd;
    assign w_free     = (i_tag_rdata == '0);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_seed    = r_seed;
        n_prod_lo = r_prod_lo;
        n_prod_hi = r_prod_hi;
        n_div     = r_div;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_got     = r_got;
        n_pcnt    = r_pcnt;
        n_pol     = r_pol;
        n_core    = r_core;
        case (r_state)
            S_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SET_W'(NUM_SETS-1)) begin
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                n_prod_lo = w_plo[SEED_W-1:0];
                n_state   = S_MUL_HI;
            end
            S_MUL_HI: begin
                n_prod_hi = w_phi[HALF_W-1:0];
                n_state   = S_ADD;
            end
            S_ADD: begin
                n_seed  = w_seed_new;
                n_div   = w_seed_new[drrip_pkg::CAND_LSB +: CAND_W];
                n_state = S_QUO;
            end
            S_QUO: begin
                n_quo   = CAND_W'(w_qprod >> QSH);
                n_state = S_REM;
            end
            S_REM: begin
                n_rem   = w_rem_full[SET_W-1:0];
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = S_MUL_LO;
                if (w_free) begin
                    n_got = r_got + 1'b1;
                    if (r_pcnt == PC_W'(DUEL_SETS_PER_POLICY-1)) begin
                        n_pcnt = '0;
                        n_pol  = ~r_pol;
                        if (r_pol) begin
                            n_core = r_core + 1'b1;
                        end
                    end else begin
                        n_pcnt = r_pcnt + 1'b1;
                    end
                    if (r_got == GOT_W'(WANT-1)) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                n_state = S_DONE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_seed  <= SEED_W'(1);
            r_rem   <= '0;
            r_got   <= '0;
            r_pcnt  <= '0;
            r_pol   <= 1'b0;
            r_core  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_seed  <= n_seed;
            r_rem   <= n_rem;
            r_got   <= n_got;
            r_pcnt  <= n_pcnt;
            r_pol   <= n_pol;
            r_core  <= n_core;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_lo <= n_prod_lo;
        r_prod_hi <= n_prod_hi;
        r_div     <= n_div;
        r_quo     <= n_quo;
    end

    always_comb begin
        o_ctl.done   = (r_state == S_DONE);
        o_ctl.row_we = (r_state == S_CLEAR);
        o_ctl.tag_we = (r_state == S_CLEAR) || ((r_state == S_CHECK) && w_free);
        o_addr       = (r_state == S_CLEAR) ? r_cnt : r_rem;
        o_tag        = (r_state == S_CLEAR) ? '0 :
                       TAG_W'(1 + 2*int'(r_core) + int'(r_pol));
    end

endmodule
`default_nettype wire

[rtl/core/drrip_victim.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// DRRIP victim selection
// Picks the first invalid way, or ages the set's RRPV row so that its
// largest value reaches the maximum and picks the first way holding it.
// ----------------------------------------------------------------------------
module drrip_victim #(
    parameter int NUM_WAYS = 8
) (
    input  wire logic [2*NUM_WAYS-1:0]              i_row,
    input  wire logic [drrip_pkg::VALID_W-1:0]      i_valid_ways,
    output drrip_pkg::t_pick                        o_pick,
    output logic      [2*NUM_WAYS-1:0]              o_aged_row
);

    logic [31:0] w_vext;
    logic        w_inv;
    logic [2:0]  w_inv_way;
    logic [2:0]  w_age_way;
    logic        w_any3, w_any2, w_any1;
    logic [1:0]  w_top;
    logic [1:0]  w_delta;

    assign w_vext = {{(32-drrip_pkg::VALID_W){1'b1}}, i_valid_ways};

    always_comb begin
        w_inv     = 1'b0;
        w_inv_way = '0;
        w_any3    = 1'b0;
        w_any2    = 1'b0;
        w_any1    = 1'b0;
        for (int w = NUM_WAYS-1; w >= 0; w--) begin
            if (!w_vext[w]) begin
                w_inv     = 1'b1;
                w_inv_way = 3'(w);
            end
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            w_any3 = w_any3 | (i_row[2*w +: 2] == 2'd3);
            w_any2 = w_any2 | (i_row[2*w +: 2] == 2'd2);
            w_any1 = w_any1 | (i_row[2*w +: 2] == 2'd1);
        end
        w_top     = w_any3 ? 2'd3 : (w_any2 ? 2'd2 : (w_any1 ? 2'd1 : 2'd0));
        w_delta   = drrip_pkg::RRPV_MAX - w_top;
        w_age_way = '0;
        for (int w = NUM_WAYS-1; w >= 0; w--) begin
            if (i_row[2*w +: 2] == w_top) begin
                w_age_way = 3'(w);
            end
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            o_aged_row[2*w +: 2] = i_row[2*w +: 2] + w_delta;
        end
        o_pick.from_invalid = w_inv;
        o_pick.way          = w_inv ? w_inv_way : w_age_way;
    end

endmodule
`default_nettype wire

[rtl/core/drrip_replacement_policy_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// DRRIP replacement policy
// Set-dueling 2-bit RRIP replacement state for one set-associative cache.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; a new word is taken
// only once the last is through: the set's RRPV row and leader tag are read
// from the memories when it is taken, and the row is modified and written
// back while busy holds the next word off. A victim request answers with
// o_valid high for exactly one cycle, through r_item and r_out_valid; an
// update gives no answer. The receiver cannot hold an answer off, so it
// must take it in the cycle that o_valid is high. After reset busy stays
// high while the memories are cleared and then while LCG candidates are tried.
// ----------------------------------------------------------------------------
module drrip_replacement_policy_top #(
    parameter int NUM_SETS             = 1024,
    parameter int NUM_WAYS             = 8,
    parameter int NUM_CORES            = 4,
    parameter int PSEL_BITS            = 10,
    parameter int DUEL_SETS_PER_POLICY = 32,
    parameter int BIP_PERIOD           = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [drrip_pkg::CMD_W-1:0]       i_command,
    input  wire logic [drrip_pkg::CPU_ID_W-1:0]    i_cpu_id,
    input  wire logic [drrip_pkg::SET_IDX_W-1:0]   i_set_index,
    input  wire logic [drrip_pkg::WAY_IDX_W-1:0]   i_way_index,
    input  wire logic                              i_hit,
    input  wire logic                              i_is_writeback,
    input  wire logic [drrip_pkg::VALID_W-1:0]     i_valid_ways,
    output logic                                   o_valid,
    output logic      [drrip_pkg::WAY_IDX_W-1:0]   o_victim_way,
    output logic                                   o_from_invalid
);

    localparam int SET_W = $clog2(NUM_SETS);
    localparam int ROW_W = 2*NUM_WAYS;
    localparam int CPU_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int TAG_W = $clog2(2*NUM_CORES+1);
    localparam int BIP_W = $clog2(BIP_PERIOD);
    localparam logic [PSEL_BITS-1:0] PSEL_TOP = '1;
    localparam logic [PSEL_BITS-1:0] PSEL_MID = PSEL_BITS'(((1 << PSEL_BITS) - 1) / 2);

    function automatic logic [SET_W-1:0] set_fold(input logic [drrip_pkg::SET_IDX_W-1:0] v);
        int r;
        r = int'(v);
        for (int k = 3; k >= 0; k--) begin
            if (r >= (NUM_SETS << k)) begin
                r = r - (NUM_SETS << k);
            end
        end
        return SET_W'(r);
    endfunction

    function automatic logic [CPU_W-1:0] cpu_fold(input logic [drrip_pkg::CPU_ID_W-1:0] v);
        int r;
        r = int'(v);
        for (int k = 1; k >= 0; k--) begin
            if (r >= (NUM_CORES << k)) begin
                r = r - (NUM_CORES << k);
            end
        end
        return CPU_W'(r);
    endfunction

    drrip_pkg::t_init_ctl  w_init;
    logic [SET_W-1:0]      w_init_addr;
    logic [TAG_W-1:0]      w_init_tag;
    logic [TAG_W-1:0]      w_tag;
    logic [ROW_W-1:0]      w_row;
    logic [ROW_W-1:0]      w_aged_row;
    drrip_pkg::t_pick      w_pick;
    logic [SET_W-1:0]      w_rd_set;
    logic                  w_accept;

    logic                  r_item;
    logic                  r_cmd;
    logic [CPU_W-1:0]      r_cpu;
    logic [SET_W-1:0]      r_set;
    logic [2:0]            r_way;
    logic                  r_hit;
    logic                  r_wb;
    logic [drrip_pkg::VALID_W-1:0] r_valid;

    logic [PSEL_BITS-1:0]  r_psel [NUM_CORES];
    logic [PSEL_BITS-1:0]  n_psel;
    logic [BIP_W-1:0]      r_bip, n_bip;
    logic                  r_out_valid;
    logic [2:0]            r_victim;
    logic                  r_from_inv;

    logic                  w_way_ok;
    logic [TAG_W-1:0]      w_tag_m1;
    logic                  w_leader;
    logic                  w_bip_lead;
    logic                  w_use_bip;
    logic                  w_fill;
    logic [BIP_W-1:0]      w_bip_next;
    logic [1:0]            w_new_val;
    logic [ROW_W-1:0]      w_new_row;
    logic                  w_row_we;
    logic [ROW_W-1:0]      w_row_wdata;
    logic [SET_W-1:0]      w_row_waddr;

    assign busy     = ~w_init.done | r_item;
    assign w_accept = start & ~busy;
    assign w_rd_set = set_fold(i_set_index);

    drrip_init #(
        .NUM_SETS             (NUM_SETS),
        .NUM_CORES            (NUM_CORES),
        .DUEL_SETS_PER_POLICY (DUEL_SETS_PER_POLICY)
    ) u_init (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag_rdata (w_tag),
        .o_ctl       (w_init),
        .o_addr      (w_init_addr),
        .o_tag       (w_init_tag)
    );

    drrip_ram #(
        .DEPTH (NUM_SETS),
        .WIDTH (TAG_W)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_init.tag_we),
        .i_waddr (w_init_addr),
        .i_wdata (w_init_tag),
        .i_raddr (w_init.done ? w_rd_set : w_init_addr),
        .o_rdata (w_tag)
    );

    drrip_ram #(
        .DEPTH (NUM_SETS),
        .WIDTH (ROW_W)
    ) u_rrpv_ram (
        .i_clk   (i_clk),
        .i_we    (w_row_we),
        .i_waddr (w_row_waddr),
        .i_wdata (w_row_wdata),
        .i_raddr (w_rd_set),
        .o_rdata (w_row)
    );

    drrip_victim #(
        .NUM_WAYS (NUM_WAYS)
    ) u_victim (
        .i_row        (w_row),
        .i_valid_ways (r_valid),
        .o_pick       (w_pick),
        .o_aged_row   (w_aged_row)
    );

    always_comb begin
        w_way_ok   = int'(r_way) < NUM_WAYS;
        w_tag_m1   = w_tag - 1'b1;
        w_leader   = (w_tag != '0) && (int'(w_tag_m1 >> 1) == int'(r_cpu));
        w_bip_lead = ~w_tag_m1[0];
        w_use_bip  = w_leader ? w_bip_lead : (r_psel[r_cpu] > PSEL_MID);
        w_bip_next = (r_bip == BIP_W'(BIP_PERIOD-1)) ? '0 : r_bip + 1'b1;
        w_fill     = r_item && (r_cmd == drrip_pkg::CMD_UPDATE) && w_way_ok && !r_wb && !r_hit;

        if (r_wb) begin
            w_new_val = drrip_pkg::RRPV_LONG;
        end else if (r_hit) begin
            w_new_val = drrip_pkg::RRPV_NEAR;
        end else if (w_use_bip) begin
            w_new_val = (w_bip_next == '0) ? drrip_pkg::RRPV_LONG : drrip_pkg::RRPV_MAX;
        end else begin
            w_new_val = drrip_pkg::RRPV_LONG;
        end

        w_new_row = w_row;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (int'(r_way) == w) begin
                w_new_row[2*w +: 2] = w_new_val;
            end
        end

        n_psel = r_psel[r_cpu];
        if (w_bip_lead) begin
            if (r_psel[r_cpu] != '0) begin
                n_psel = r_psel[r_cpu] - 1'b1;
            end
        end else begin
            if (r_psel[r_cpu] != PSEL_TOP) begin
                n_psel = r_psel[r_cpu] + 1'b1;
            end
        end
        n_bip = (w_fill && w_use_bip) ? w_bip_next : r_bip;

        if (!w_init.done) begin
            w_row_we    = w_init.row_we;
            w_row_waddr = w_init_addr;
            w_row_wdata = '1;
        end else if (r_cmd == drrip_pkg::CMD_VICTIM) begin
            w_row_we    = r_item && !w_pick.from_invalid;
            w_row_waddr = r_set;
            w_row_wdata = w_aged_row;
        end else begin
            w_row_we    = r_item && w_way_ok;
            w_row_waddr = r_set;
            w_row_wdata = w_new_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item      <= 1'b0;
            r_out_valid <= 1'b0;
            r_bip       <= '0;
            for (int c = 0; c < NUM_CORES; c++) begin
                r_psel[c] <= '0;
            end
        end else begin
            r_item      <= w_accept;
            r_out_valid <= r_item && (r_cmd == drrip_pkg::CMD_VICTIM);
            r_bip       <= n_bip;
            if (w_fill && w_leader) begin
                r_psel[r_cpu] <= n_psel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_command;
            r_cpu   <= cpu_fold(i_cpu_id);
            r_set   <= w_rd_set;
            r_way   <= i_way_index;
            r_hit   <= i_hit;
            r_wb    <= i_is_writeback;
            r_valid <= i_valid_ways;
        end
        if (r_item) begin
            r_victim   <= w_pick.way;
            r_from_inv <= w_pick.from_invalid;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_victim_way   = r_victim;
    assign o_from_invalid = r_from_inv;

endmodule
`default_nettype wire
